[design/sis_pkg.sv]
package sis_pkg;

  localparam int unsigned IdxW = 11;
  localparam int unsigned RankW = 10;
  localparam int unsigned ModeW = 3;
  localparam int unsigned WordW = 8;
  localparam int unsigned SetMaxDefault = 1024;
  localparam logic [IdxW-1:0] SetSizeReset = IdxW'(1024);

  typedef enum logic [ModeW-1:0] {
    MODE_ADD        = 3'd0,
    MODE_REMOVE     = 3'd1,
    MODE_ADD_RANGE  = 3'd2,
    MODE_REM_RANGE  = 3'd3,
    MODE_ADD_ALL    = 3'd4,
    MODE_REMOVE_ALL = 3'd5,
    MODE_READ       = 3'd6
  } mode_e;

  typedef struct packed {
    logic load;
    logic rd;
    logic wr;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep;
  } dp_status_t;

  function automatic logic [3:0] popcount8(input logic [WordW-1:0] w);
    logic [3:0] c;
    c = '0;
    for (int b = 0; b < WordW; b++) begin
      c = c + 4'(w[b]);
    end
    return c;
  endfunction

endpackage

[design/sis_ctrl.sv]
module sis_ctrl #(
  parameter int unsigned NumWords = 128,
  parameter int unsigned AddrW = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  sis_pkg::dp_status_t    status_i,
  output sis_pkg::ctrl_cmd_t     cmd_o,
  output logic [AddrW-1:0]       addr_o,
  output logic                   busy_o
);
  import sis_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHECK  = 5'b00010,
    ST_READ   = 5'b00100,
    ST_MODIFY = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [AddrW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cnt_d = '0;
        state_d = status_i.sweep ? ST_READ : ST_DONE;
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d = ST_MODIFY;
      end
      ST_MODIFY: begin
        cmd_o.wr = 1'b1;
        if (cnt_q == AddrW'(NumWords - 1)) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
          state_d = ST_READ;
        end
      end
      ST_DONE: begin
        cmd_o.finish = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  assign addr_o = cnt_q;
  assign busy_o = (state_q != ST_IDLE);

endmodule

[design/sis_dp.sv]
module sis_dp #(
  parameter int unsigned SetMax = 1024,
  parameter int unsigned NumWords = 128,
  parameter int unsigned AddrW = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sis_pkg::ctrl_cmd_t            cmd_i,
  input  logic [AddrW-1:0]              addr_i,
  output sis_pkg::dp_status_t           status_o,
  input  logic [sis_pkg::IdxW-1:0]      set_size_i,
  input  logic [sis_pkg::ModeW-1:0]     mode_i,
  input  logic [sis_pkg::IdxW-1:0]      first_index_i,
  input  logic [sis_pkg::IdxW-1:0]      last_index_i,
  input  logic [sis_pkg::RankW-1:0]     rank_i,
  output logic                          done_o,
  output logic [sis_pkg::IdxW-1:0]      member_count_o,
  output logic [sis_pkg::IdxW-1:0]      changed_count_o,
  output logic [sis_pkg::IdxW-1:0]      read_value_o,
  output logic                          error_o
);
  import sis_pkg::*;

  logic [WordW-1:0] mem [NumWords];
  logic [NumWords-1:0] valid_q;
  logic [WordW-1:0] rdata_q;
  logic rvalid_q;

  logic [ModeW-1:0] mode_q;
  logic [IdxW-1:0] first_q, last_q, lim_q;
  logic [RankW-1:0] rank_q;
  logic [IdxW-1:0] total_q, chg_q, acc_q, readv_q;
  logic found_q, err_q, sweep_q;
  logic done_q;
  logic [IdxW-1:0] cnt_out_q, chg_out_q, readv_out_q;
  logic err_out_q;

  logic [IdxW-1:0] lim;
  logic range_ok, idx_ok;
  logic [WordW-1:0] old_w, new_w, mask;
  logic [31:0] lo, hi, base;
  logic modifies;
  logic [3:0] pc, dpc;
  logic [IdxW-1:0] k_full;
  logic [2:0] k;
  logic [3:0] run;
  logic hit;
  logic [2:0] hit_pos;
  logic [IdxW-1:0] cnt_d, chg_d;

  assign lim = ({21'b0, set_size_i} > 32'(SetMax)) ? IdxW'(SetMax) : set_size_i;
  assign idx_ok = (first_index_i >= IdxW'(1)) && (first_index_i <= lim);
  assign range_ok = (first_index_i >= IdxW'(1)) && (last_index_i <= lim) &&
                    (first_index_i <= last_index_i);

  assign old_w = rvalid_q ? rdata_q : '0;
  assign base = 32'(addr_i) * WordW;

  always_comb begin
    lo = {21'b0, first_q};
    hi = {21'b0, last_q};
    if (mode_q == MODE_ADD || mode_q == MODE_REMOVE) begin
      hi = {21'b0, first_q};
    end else if (mode_q == MODE_ADD_ALL) begin
      lo = 32'd1;
      hi = {21'b0, lim_q};
    end
    for (int b = 0; b < WordW; b++) begin
      mask[b] = ((base + 32'(b) + 32'd1) >= lo) && ((base + 32'(b) + 32'd1) <= hi) &&
                ((base + 32'(b) + 32'd1) <= 32'(SetMax));
    end
    modifies = 1'b1;
    case (mode_q)
      MODE_ADD, MODE_ADD_RANGE: new_w = old_w | mask;
      MODE_REMOVE, MODE_REM_RANGE: new_w = old_w & ~mask;
      MODE_ADD_ALL: new_w = mask;
      default: begin
        new_w = old_w;
        modifies = 1'b0;
      end
    endcase
  end

  assign pc = popcount8(old_w);
  assign dpc = popcount8(old_w ^ new_w);
  assign k_full = IdxW'(rank_q) - acc_q;
  assign k = k_full[2:0];

  always_comb begin
    run = '0;
    hit_pos = '0;
    hit = 1'b0;
    for (int b = 0; b < WordW; b++) begin
      if (old_w[b] && !hit && run == {1'b0, k}) begin
        hit = 1'b1;
        hit_pos = 3'(b);
      end
      run = run + 4'(old_w[b]);
    end
  end

  always_comb begin
    cnt_d = total_q;
    chg_d = '0;
    case (mode_q)
      MODE_ADD, MODE_ADD_RANGE: begin
        cnt_d = total_q + chg_q;
        chg_d = chg_q;
      end
      MODE_REMOVE, MODE_REM_RANGE: begin
        cnt_d = total_q - chg_q;
        chg_d = chg_q;
      end
      MODE_ADD_ALL: begin
        if (sweep_q) begin
          cnt_d = lim_q;
          chg_d = lim_q - total_q;
        end
      end
      MODE_REMOVE_ALL: begin
        cnt_d = '0;
        chg_d = total_q;
      end
      default: begin
        cnt_d = total_q;
        chg_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rdata_q <= mem[addr_i];
    end
    if (cmd_i.wr && modifies) begin
      mem[addr_i] <= new_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvalid_q <= 1'b0;
      total_q <= '0;
      done_q <= 1'b0;
      sweep_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.rd) begin
        rvalid_q <= valid_q[addr_i];
      end
      if (cmd_i.wr && modifies) begin
        valid_q[addr_i] <= 1'b1;
      end
      if (cmd_i.load) begin
        case (mode_i)
          MODE_ADD: sweep_q <= idx_ok;
          MODE_REMOVE, MODE_READ: sweep_q <= 1'b1;
          MODE_ADD_RANGE, MODE_REM_RANGE: sweep_q <= range_ok;
          MODE_ADD_ALL: sweep_q <= (total_q < lim);
          default: sweep_q <= 1'b0;
        endcase
      end
      if (cmd_i.finish) begin
        total_q <= cnt_d;
        if (mode_q == MODE_REMOVE_ALL) begin
          valid_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      first_q <= first_index_i;
      last_q <= last_index_i;
      rank_q <= rank_i;
      lim_q <= lim;
      chg_q <= '0;
      acc_q <= '0;
      found_q <= 1'b0;
      readv_q <= '0;
      case (mode_i)
        MODE_ADD: err_q <= !idx_ok;
        MODE_ADD_RANGE, MODE_REM_RANGE: err_q <= !range_ok;
        default: err_q <= 1'b0;
      endcase
    end
    if (cmd_i.wr) begin
      chg_q <= chg_q + IdxW'(dpc);
      acc_q <= acc_q + IdxW'(pc);
      if (mode_q == MODE_READ && !found_q && (acc_q + IdxW'(pc)) > IdxW'(rank_q)) begin
        found_q <= 1'b1;
        readv_q <= IdxW'(base + 32'(hit_pos) + 32'd1);
      end
    end
    if (cmd_i.finish) begin
      cnt_out_q <= cnt_d;
      chg_out_q <= chg_d;
      readv_out_q <= (mode_q == MODE_READ && found_q) ? readv_q : '0;
      err_out_q <= err_q;
    end
  end

  assign status_o.sweep = sweep_q;
  assign done_o = done_q;
  assign member_count_o = cnt_out_q;
  assign changed_count_o = chg_out_q;
  assign read_value_o = readv_out_q;
  assign error_o = err_out_q;

endmodule

[design/sorted_index_subset_store.sv]
// Sorted index subset store. A command is taken when start is high and busy is low; its
// single result appears on the result ports as done_o goes high for exactly one cycle, and the
// receiver cannot stall it. The set is held as a bitmap in a memory of 8-bit words, and every
// sweeping command walks all words, reading and then updating each word in turn, while
// refused commands, remove all, add all with nothing to add and undefined modes go from the
// check state straight to done without a walk. Remove all clears the per-word valid flags at
// once, so no clearing pass is needed after reset.
module sorted_index_subset_store #(
  parameter int unsigned SET_MAX = sis_pkg::SetMaxDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [sis_pkg::ModeW-1:0]     mode_i,
  input  logic [sis_pkg::IdxW-1:0]      first_index_i,
  input  logic [sis_pkg::IdxW-1:0]      last_index_i,
  input  logic [sis_pkg::RankW-1:0]     rank_i,
  output logic                          done_o,
  output logic [sis_pkg::IdxW-1:0]      member_count_o,
  output logic [sis_pkg::IdxW-1:0]      changed_count_o,
  output logic [sis_pkg::IdxW-1:0]      read_value_o,
  output logic                          error_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import sis_pkg::*;

  localparam int unsigned NumWords = (SET_MAX + WordW - 1) / WordW;
  localparam int unsigned AddrW = (NumWords > 1) ? $clog2(NumWords) : 1;

  logic [IdxW-1:0] set_size_q;
  ctrl_cmd_t cmd;
  dp_status_t status;
  logic [AddrW-1:0] addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size_q <= SetSizeReset;
    end else if (psel && penable && pwrite && paddr == 3'd0) begin
      set_size_q <= pwdata[IdxW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {21'b0, set_size_q} : 32'b0;

  sis_ctrl #(
    .NumWords(NumWords),
    .AddrW(AddrW)
  ) u_ctrl (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start),
    .status_i(status),
    .cmd_o(cmd),
    .addr_o(addr),
    .busy_o(busy)
  );

  sis_dp #(
    .SetMax(SET_MAX),
    .NumWords(NumWords),
    .AddrW(AddrW)
  ) u_dp (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cmd_i(cmd),
    .addr_i(addr),
    .status_o(status),
    .set_size_i(set_size_q),
    .mode_i(mode_i),
    .first_index_i(first_index_i),
    .last_index_i(last_index_i),
    .rank_i(rank_i),
    .done_o(done_o),
    .member_count_o(member_count_o),
    .changed_count_o(changed_count_o),
    .read_value_o(read_value_o),
    .error_o(error_o)
  );

endmodule
